>>> rtl/neighbor_aware_color_choice_assert.svh
// ---------------------------------------------------------------------------
// neighbor-aware color choice assertion macros
// shared clocked assertion forms with reset disable
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_AWARE_COLOR_CHOICE_ASSERT_SVH
`define NEIGHBOR_AWARE_COLOR_CHOICE_ASSERT_SVH

// property holds on every clock edge outside reset
`define NACC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies the consequent in the next
`define NACC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/nacc_pkg.sv
// ---------------------------------------------------------------------------
// nacc_pkg
// types and constants shared by the color choice block
// ---------------------------------------------------------------------------
package nacc_pkg;

  localparam int unsigned COLOR_COUNT = 64;
  localparam int unsigned LIST_DEPTH  = 64;
  localparam int unsigned COLOR_W     = 6;
  localparam int unsigned COLOR_AW    = $clog2(COLOR_COUNT);
  localparam int unsigned LIST_AW     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(LIST_DEPTH + 1);

  typedef enum logic {
    OP_ALLOWED  = 1'b0,
    OP_NEIGHBOR = 1'b1
  } nacc_op_e;

  typedef enum logic [1:0] {
    OUT_REPEAT = 2'd0,
    OUT_FIRST  = 2'd1,
    OUT_USED   = 2'd2,
    OUT_EMPTY  = 2'd3
  } nacc_outcome_e;

  typedef struct packed {
    nacc_op_e             opcode;
    logic [COLOR_W-1:0]   color_value;
    logic                 last;
  } nacc_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0]   chosen_color;
    nacc_outcome_e        outcome;
  } nacc_out_t;

  // job status seen by the decision sequencer
  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic                 repeat_found;
    logic [COLOR_W-1:0]   repeat_color;
    logic                 overlap;
  } nacc_stat_t;

  // list write request
  typedef struct packed {
    logic                 en;
    logic [LIST_AW-1:0]   addr;
    logic [COLOR_W-1:0]   data;
  } nacc_wr_t;

endpackage

>>> rtl/nacc_list_ram.sv
// ---------------------------------------------------------------------------
// nacc_list_ram
// single write port, single registered read port memory
// ---------------------------------------------------------------------------
module nacc_list_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 6,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/nacc_mask_unit.sv
// ---------------------------------------------------------------------------
// nacc_mask_unit
// allowed and seen masks, list fill count and repeat record of one job
// ---------------------------------------------------------------------------
module nacc_mask_unit import nacc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  nacc_in_t           item_i,
  input  logic               clear_i,
  input  logic [COLOR_W-1:0] query_i,
  output logic               seen_hit_o,
  output nacc_stat_t         stat_o,
  output nacc_wr_t           wr_o
);

  logic [COLOR_COUNT-1:0] allowed_q, allowed_d;
  logic [COLOR_COUNT-1:0] seen_q, seen_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   repeat_q, repeat_d;
  logic [COLOR_W-1:0]     rcolor_q, rcolor_d;

  logic                in_range;
  logic                full;
  logic [COLOR_AW-1:0] cidx;

  assign in_range = int'(item_i.color_value) < COLOR_COUNT;
  assign full     = (count_q == CNT_W'(LIST_DEPTH));
  assign cidx     = item_i.color_value[COLOR_AW-1:0];

  always_comb begin
    allowed_d = allowed_q;
    seen_d    = seen_q;
    count_d   = count_q;
    repeat_d  = repeat_q;
    rcolor_d  = rcolor_q;
    wr_o.en   = 1'b0;
    wr_o.addr = count_q[LIST_AW-1:0];
    wr_o.data = item_i.color_value;
    if (clear_i) begin
      allowed_d = '0;
      seen_d    = '0;
      count_d   = '0;
      repeat_d  = 1'b0;
      rcolor_d  = '0;
    end else if (upd_i && in_range) begin
      if (item_i.opcode == OP_ALLOWED) begin
        if (!full) begin
          wr_o.en         = 1'b1;
          count_d         = count_q + CNT_W'(1);
          allowed_d[cidx] = 1'b1;
        end
      end else if (!repeat_q) begin
        if (!seen_q[cidx]) begin
          seen_d[cidx] = 1'b1;
        end else if (allowed_q[cidx]) begin
          repeat_d = 1'b1;
          rcolor_d = item_i.color_value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_q <= '0;
      seen_q    <= '0;
      count_q   <= '0;
      repeat_q  <= 1'b0;
      rcolor_q  <= '0;
    end else begin
      allowed_q <= allowed_d;
      seen_q    <= seen_d;
      count_q   <= count_d;
      repeat_q  <= repeat_d;
      rcolor_q  <= rcolor_d;
    end
  end

  // listed colors are always in range, so the low bits index the mask
  assign seen_hit_o = seen_q[query_i[COLOR_AW-1:0]];

  assign stat_o.count        = count_q;
  assign stat_o.repeat_found = repeat_q;
  assign stat_o.repeat_color = rcolor_q;
  assign stat_o.overlap      = |(allowed_q & seen_q);

endmodule

>>> rtl/neighbor_aware_color_choice.sv
// ---------------------------------------------------------------------------
// neighbor_aware_color_choice
// picks a cell color from its ordered allowed list and its neighbors' colors
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  item in  | start_i & !busy_o       | in_i  (opcode, color_value, last)
//  result   | done_o, one cycle       | res_o (chosen_color, outcome)
//
//  an item without last leaves busy_o low
//  a last item is answered from the decision state when a repeat was found or
//  the list is empty, otherwise after a scan from the list head to the chosen entry:
//  the ordered scan reads the list memory one entry per cycle
//  reset clears the masks, count and repeat record; the list needs no clear
//  the result shows in the cycle after the decision; the receiver cannot stall
// ---------------------------------------------------------------------------
`include "neighbor_aware_color_choice_assert.svh"

module neighbor_aware_color_choice import nacc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  nacc_in_t  in_i,
  output logic      busy_o,
  output logic      done_o,
  output nacc_out_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECIDE = 3'b010,
    ST_SCAN   = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [LIST_AW-1:0] idx_q, idx_d;
  logic               pend_q, pend_d;
  logic               first_q, first_d;
  logic               done_q, done_d;
  nacc_out_t          res_q, res_d;

  logic               accept;
  logic               clear;
  logic               rd_en;
  logic [LIST_AW-1:0] rd_addr;
  logic [COLOR_W-1:0] rd_data;
  logic               seen_hit;
  nacc_stat_t         stat;
  nacc_wr_t           wr;

  assign accept = start_i && (state_q == ST_IDLE);

  nacc_mask_unit u_mask (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (accept),
    .item_i     (in_i),
    .clear_i    (clear),
    .query_i    (rd_data),
    .seen_hit_o (seen_hit),
    .stat_o     (stat),
    .wr_o       (wr)
  );

  nacc_list_ram #(
    .Depth (LIST_DEPTH),
    .Width (COLOR_W)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    first_d = first_q;
    done_d  = 1'b0;
    res_d   = res_q;
    clear   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_i.last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.repeat_found) begin
          done_d             = 1'b1;
          res_d.chosen_color = stat.repeat_color;
          res_d.outcome      = OUT_REPEAT;
          clear              = 1'b1;
          state_d            = ST_IDLE;
        end else if (stat.count == '0) begin
          done_d             = 1'b1;
          res_d.chosen_color = '0;
          res_d.outcome      = OUT_EMPTY;
          clear              = 1'b1;
          state_d            = ST_IDLE;
        end else begin
          // no overlap takes the head entry without testing it
          rd_en   = 1'b1;
          rd_addr = '0;
          idx_d   = LIST_AW'(1);
          pend_d  = 1'b1;
          first_d = !stat.overlap;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_q && (first_q || seen_hit)) begin
          done_d             = 1'b1;
          res_d.chosen_color = rd_data;
          res_d.outcome      = first_q ? OUT_FIRST : OUT_USED;
          clear              = 1'b1;
          state_d            = ST_IDLE;
        end else begin
          rd_en  = 1'b1;
          idx_d  = idx_q + LIST_AW'(1);
          pend_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `NACC_ASSERT_NEXT(a_last_goes_busy, clk_i, rst_ni, start_i && !busy_o && in_i.last, busy_o, "last item did not start the decision")
  `NACC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe held two cycles")
  `NACC_ASSERT(a_scan_nonempty, clk_i, rst_ni, (state_q != ST_SCAN) || (stat.count != '0), "list scan with empty list")
  `NACC_ASSERT(a_empty_color_zero, clk_i, rst_ni, !(done_o && res_o.outcome == OUT_EMPTY) || (res_o.chosen_color == '0), "empty job gave nonzero color")

endmodule
